/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");

`endif

/* src/lifeca_pkg.sv */
// ----------------------------------------------------------------------------
// lifeca_pkg
// Types and constants shared by the cell update core and its datapath.
// ----------------------------------------------------------------------------
package lifeca_pkg;

  localparam int RULE_W = 18;

  // Grid store dimensions, fixed by the six-bit row and column fields.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // Request codes on the input word.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_RULE = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  localparam logic [RULE_W-1:0] RULE_RESET = 18'd6152;
  localparam logic [6:0]        SIZE_RESET = 7'd64;

  localparam logic [7:0] LIVE_RED   = 8'd255;
  localparam logic [7:0] DEAD_RED   = 8'd0;
  localparam logic [4:0] SURVIVE_OFS = 5'd9;

  // Per-cycle control for the neighbour counter.
  typedef struct packed {
    logic first;   // row above arrives: restart the count
    logic centre;  // addressed row arrives: skip and keep the centre cell
    logic last;    // row below arrives: finish and look up the rule
  } eval_ctrl_t;

endpackage

/* src/life_like_automaton_cell_update_core.sv */
// ----------------------------------------------------------------------------
// life_like_automaton_cell_update_core
// Toroidal life-like automaton: load cells, evaluate one cell's next state.
// ----------------------------------------------------------------------------
// A word is offered on the in_ ports with start; it is taken at a clock edge
// where start is high and busy is low. A load word writes one cell (live when
// the red byte is 255) and yields no result; busy stays low, so loads may
// follow one another in every cycle. An evaluate word raises busy through
// the states S_ROW1, S_ROW2 and S_ROW3, one per row word read from the grid
// memory (row above, addressed row, row below). The result word appears on
// the out_ ports with out_valid for exactly one cycle, registered as the
// block leaves S_ROW3; busy is already low then, so the next word may be
// accepted at the edge that ends that cycle. Evaluates never overlap: each
// makes its three memory reads and returns to idle before the next is taken.
// The receiver cannot stall the block, so results are simply presented and
// never held. Words addressing a cell outside the configured grid are taken
// and dropped. The APB port sets the rule and grid size and should only be
// written while the block is idle. Reset restores Conway's rule and a
// full-size grid; the grid contents are undefined until loaded, and there is
// no clearing pass.
// ----------------------------------------------------------------------------
module life_like_automaton_cell_update_core (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [5:0]  in_cell_row,
  input  logic [5:0]  in_cell_col,
  input  logic [7:0]  in_red_value,
  // result channel
  output logic        out_valid,
  output logic [7:0]  out_next_color,
  output logic        out_next_alive,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import lifeca_pkg::*;

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RSZ_W  = $clog2(MAX_ROWS + 1);
  localparam int CSZ_W  = $clog2(MAX_COLS + 1);
  localparam int RC_W   = (RSZ_W > CSZ_W) ? RSZ_W : CSZ_W;
  // Wide enough for the 7-bit size registers and for either maximum.
  localparam int SZ_W   = (RC_W > 7) ? RC_W : 7;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROW1 = 4'b0010,
    S_ROW2 = 4'b0100,
    S_ROW3 = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [RULE_W-1:0] rule_r, rule_nxt;
  logic [6:0]        rows_r, rows_nxt;
  logic [6:0]        cols_r, cols_nxt;

  logic [ROW_AW-1:0] row_mid_r, row_mid_nxt;
  logic [ROW_AW-1:0] row_next_r, row_next_nxt;
  logic [COL_AW-1:0] col_prev_r, col_prev_nxt;
  logic [COL_AW-1:0] col_mid_r, col_mid_nxt;
  logic [COL_AW-1:0] col_next_r, col_next_nxt;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; pready is tied
  // high so every access ends in its access phase with no wait states.
  // --------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    rule_nxt = rule_r;
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RULE: rule_nxt = pwdata[RULE_W-1:0];
        REG_ROWS: rows_nxt = pwdata[6:0];
        REG_COLS: cols_nxt = pwdata[6:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RULE: prdata = {{(32-RULE_W){1'b0}}, rule_r};
      REG_ROWS: prdata = {25'd0, rows_r};
      REG_COLS: prdata = {25'd0, cols_r};
      default:  prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Effective grid size: zero behaves as one, anything above the built size
  // behaves as the built size.
  // --------------------------------------------------------------------------
  logic [SZ_W-1:0] rows_w, cols_w, nr, nc;

  always_comb begin
    rows_w = SZ_W'(rows_r);
    cols_w = SZ_W'(cols_r);
    if (rows_w == '0) begin
      nr = SZ_W'(1);
    end else if (rows_w > SZ_W'(MAX_ROWS)) begin
      nr = SZ_W'(MAX_ROWS);
    end else begin
      nr = rows_w;
    end
    if (cols_w == '0) begin
      nc = SZ_W'(1);
    end else if (cols_w > SZ_W'(MAX_COLS)) begin
      nc = SZ_W'(MAX_COLS);
    end else begin
      nc = cols_w;
    end
  end

  // --------------------------------------------------------------------------
  // Wrapped neighbour coordinates of the offered cell.
  // --------------------------------------------------------------------------
  logic [SZ_W-1:0] row_w, col_w;
  logic [SZ_W-1:0] row_prev_w, row_next_w, col_prev_w, col_next_w;
  logic            in_range;

  always_comb begin
    row_w      = SZ_W'(in_cell_row);
    col_w      = SZ_W'(in_cell_col);
    in_range   = (row_w < nr) && (col_w < nc);
    row_prev_w = (row_w == '0) ? nr - SZ_W'(1) : row_w - SZ_W'(1);
    row_next_w = (row_w + SZ_W'(1) >= nr) ? '0 : row_w + SZ_W'(1);
    col_prev_w = (col_w == '0) ? nc - SZ_W'(1) : col_w - SZ_W'(1);
    col_next_w = (col_w + SZ_W'(1) >= nc) ? '0 : col_w + SZ_W'(1);
  end

  logic accept, do_load, do_eval;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start & ~busy;
  assign do_load = accept & in_range & (in_req_type == REQ_LOAD);
  assign do_eval = accept & in_range & (in_req_type == REQ_EVAL);

  // --------------------------------------------------------------------------
  // Sequencer. The row above is read on the accepting edge; the addressed row
  // and the row below are read from S_ROW1 and S_ROW2. Each read is
  // registered, so the counter sees one row word in each busy state.
  // --------------------------------------------------------------------------
  logic              rd_en;
  logic [ROW_AW-1:0] rd_row;
  eval_ctrl_t        ctrl;

  always_comb begin
    state_nxt    = state_r;
    row_mid_nxt  = row_mid_r;
    row_next_nxt = row_next_r;
    col_prev_nxt = col_prev_r;
    col_mid_nxt  = col_mid_r;
    col_next_nxt = col_next_r;
    rd_en        = 1'b0;
    rd_row       = row_mid_r;
    ctrl         = '0;
    unique case (state_r)
      S_IDLE: begin
        rd_row = row_prev_w[ROW_AW-1:0];
        if (do_eval) begin
          rd_en        = 1'b1;
          row_mid_nxt  = row_w[ROW_AW-1:0];
          row_next_nxt = row_next_w[ROW_AW-1:0];
          col_prev_nxt = col_prev_w[COL_AW-1:0];
          col_mid_nxt  = col_w[COL_AW-1:0];
          col_next_nxt = col_next_w[COL_AW-1:0];
          state_nxt    = S_ROW1;
        end
      end
      S_ROW1: begin
        rd_en      = 1'b1;
        rd_row     = row_mid_r;
        ctrl.first = 1'b1;
        state_nxt  = S_ROW2;
      end
      S_ROW2: begin
        rd_en       = 1'b1;
        rd_row      = row_next_r;
        ctrl.centre = 1'b1;
        state_nxt   = S_ROW3;
      end
      S_ROW3: begin
        ctrl.last = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rule_r  <= RULE_RESET;
      rows_r  <= SIZE_RESET;
      cols_r  <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      rule_r  <= rule_nxt;
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_mid_r  <= row_mid_nxt;
    row_next_r <= row_next_nxt;
    col_prev_r <= col_prev_nxt;
    col_mid_r  <= col_mid_nxt;
    col_next_r <= col_next_nxt;
  end

  // --------------------------------------------------------------------------
  // Grid memory and neighbour counter. A load written on one edge is seen by
  // an evaluate accepted on any later edge, since its reads come after the write.
  // --------------------------------------------------------------------------
  logic [MAX_COLS-1:0] rd_data;
  logic                res_valid, res_alive;

  lifeca_row_mem #(
    .ROWS   (MAX_ROWS),
    .COLS   (MAX_COLS),
    .ROW_AW (ROW_AW),
    .COL_AW (COL_AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_row  (row_w[ROW_AW-1:0]),
    .wr_col  (col_w[COL_AW-1:0]),
    .wr_bit  (in_red_value == LIVE_RED),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  lifeca_nbr_count #(
    .COLS   (MAX_COLS),
    .COL_AW (COL_AW)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .rd_data   (rd_data),
    .col_prev  (col_prev_r),
    .col_mid   (col_mid_r),
    .col_next  (col_next_r),
    .rule_bits (rule_r),
    .res_valid (res_valid),
    .res_alive (res_alive)
  );

  assign out_valid      = res_valid;
  assign out_next_alive = res_alive;
  assign out_next_color = res_alive ? LIVE_RED : DEAD_RED;

endmodule

/* src/lifeca_row_mem.sv */
// ----------------------------------------------------------------------------
// lifeca_row_mem
// Grid store: one word per row, one bit per cell, registered read.
// ----------------------------------------------------------------------------
module lifeca_row_mem #(
  parameter int ROWS   = 64,
  parameter int COLS   = 64,
  parameter int ROW_AW = 6,
  parameter int COL_AW = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ROW_AW-1:0] wr_row,
  input  logic [COL_AW-1:0] wr_col,
  input  logic              wr_bit,
  input  logic              rd_en,
  input  logic [ROW_AW-1:0] rd_row,
  output logic [COLS-1:0]   rd_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rd_data_r;

  // Loads write a single cell of a row; contents are undefined until written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_col] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/lifeca_nbr_count.sv */
// ----------------------------------------------------------------------------
// lifeca_nbr_count
// Accumulates live neighbours over three row words and applies the rule.
// ----------------------------------------------------------------------------
module lifeca_nbr_count #(
  parameter int COLS   = 64,
  parameter int COL_AW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lifeca_pkg::eval_ctrl_t      ctrl,
  input  logic [COLS-1:0]             rd_data,
  input  logic [COL_AW-1:0]           col_prev,
  input  logic [COL_AW-1:0]           col_mid,
  input  logic [COL_AW-1:0]           col_next,
  input  logic [lifeca_pkg::RULE_W-1:0] rule_bits,
  output logic                        res_valid,
  output logic                        res_alive
);

  import lifeca_pkg::*;

  logic [3:0] count_r, count_nxt;
  logic       centre_r, centre_nxt;
  logic       valid_r, valid_nxt;
  logic       alive_r, alive_nxt;

  logic [1:0] side_sum;
  logic [1:0] row_sum;
  logic [3:0] base;
  logic [3:0] total;
  logic [4:0] rule_idx;

  always_comb begin
    side_sum = {1'b0, rd_data[col_prev]} + {1'b0, rd_data[col_next]};
    row_sum  = ctrl.centre ? side_sum : side_sum + {1'b0, rd_data[col_mid]};
    base     = ctrl.first ? 4'd0 : count_r;
    total    = base + {2'b00, row_sum};
    rule_idx = centre_r ? {1'b0, total} + SURVIVE_OFS : {1'b0, total};

    count_nxt  = count_r;
    centre_nxt = centre_r;
    valid_nxt  = 1'b0;
    alive_nxt  = alive_r;
    if (ctrl.first || ctrl.centre) begin
      count_nxt = total;
    end
    if (ctrl.centre) begin
      centre_nxt = rd_data[col_mid];
    end
    if (ctrl.last) begin
      valid_nxt = 1'b1;
      alive_nxt = rule_bits[rule_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r  <= count_nxt;
    centre_r <= centre_nxt;
    alive_r  <= alive_nxt;
  end

  assign res_valid = valid_r;
  assign res_alive = alive_r;

endmodule

/* src/lifeca_checker.sv */
// ----------------------------------------------------------------------------
// lifeca_checker
// Port-level checks on the cell update core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifeca_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_req_type,
  input logic       out_valid,
  input logic [7:0] out_next_color,
  input logic       out_next_alive,
  input logic       pready
);

  import lifeca_pkg::*;

  logic colour_ok;
  logic load_taken;

  assign colour_ok  = (out_next_color == (out_next_alive ? LIVE_RED : DEAD_RED));
  assign load_taken = start && !busy && (in_req_type == REQ_LOAD);

  // A result word only follows the last busy cycle of an evaluate.
  `ASSERT_SAME(a_result_after_busy, clk, rst_n, out_valid, $past(busy) && !busy)

  // The colour byte mirrors the live flag.
  `ASSERT_SAME(a_colour_matches, clk, rst_n, out_valid, colour_ok)

  // A load never occupies the block.
  `ASSERT_NEXT(a_load_no_busy, clk, rst_n, load_taken, !busy && !out_valid)

  // The configuration port never inserts wait states.
  `ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready)

endmodule

bind life_like_automaton_cell_update_core lifeca_checker u_lifeca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_next_color (out_next_color),
  .out_next_alive (out_next_alive),
  .pready         (pready)
);

/* dv/lifeca_update_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifeca_update_checker
// Watches the command, result and configuration ports of the cell update
// core. It keeps its own copy of the grid and the registers, predicts the
// outcome of every accepted evaluate word inside the grid and compares each
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module lifeca_update_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_req_type,
  input  logic [5:0]  in_cell_row,
  input  logic [5:0]  in_cell_col,
  input  logic [7:0]  in_red_value,
  input  logic        out_valid,
  input  logic [7:0]  out_next_color,
  input  logic        out_next_alive,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          compared
);

  import lifeca_pkg::*;

  localparam int GRID_MAX = 64;

  typedef struct packed {
    logic [7:0] color;
    logic       alive;
  } next_gen_t;

  logic [RULE_W-1:0] rule_q;
  logic [6:0]        rows_q;
  logic [6:0]        cols_q;
  bit                live_map [GRID_MAX][GRID_MAX];
  next_gen_t         next_gen_q [$];
  int                mismatch_count = 0;
  int                compare_count = 0;
  int                pending_count = 0;

  assign mismatches = mismatch_count;
  assign pending    = pending_count;
  assign compared   = compare_count;

  function automatic int active_size(logic [6:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  // Count the eight wrapped neighbours and look the count up in the rule.
  function automatic next_gen_t next_generation(int row, int col);
    int nr, nc, dr, dc, count, rule_index;
    next_gen_t res;
    nr = active_size(rows_q);
    nc = active_size(cols_q);
    count = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          count += live_map[(row + dr + nr) % nr][(col + dc + nc) % nc];
        end
      end
    end
    rule_index = live_map[row][col] ? count + SURVIVE_OFS : count;
    res.alive = rule_q[rule_index];
    res.color = res.alive ? LIVE_RED : DEAD_RED;
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t ns] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    next_gen_t want;
    if (!rst_n) begin
      rule_q = RULE_RESET;
      rows_q = SIZE_RESET;
      cols_q = SIZE_RESET;
      next_gen_q.delete();
    end else begin
      if (out_valid) begin
        if (next_gen_q.size() == 0) begin
          flag_mismatch("result word with no evaluate outstanding");
        end else begin
          want = next_gen_q.pop_front();
          compare_count++;
          if (out_next_color !== want.color) begin
            flag_mismatch($sformatf("next_color %0d, expected %0d",
                                    out_next_color, want.color));
          end
          if (out_next_alive !== want.alive) begin
            flag_mismatch($sformatf("next_alive %0d, expected %0d",
                                    out_next_alive, want.alive));
          end
        end
      end
      if (start && !busy) begin
        if (in_cell_row < active_size(rows_q) && in_cell_col < active_size(cols_q)) begin
          if (in_req_type == REQ_LOAD) begin
            live_map[in_cell_row][in_cell_col] = (in_red_value == LIVE_RED);
          end else begin
            next_gen_q.push_back(next_generation(in_cell_row, in_cell_col));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RULE: rule_q = pwdata[RULE_W-1:0];
          REG_ROWS: rows_q = pwdata[6:0];
          REG_COLS: cols_q = pwdata[6:0];
          default: ;
        endcase
      end
    end
    pending_count = next_gen_q.size();
  end

endmodule

/* dv/tb_life_like_automaton_cell_update_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_like_automaton_cell_update_core
// Drives load and evaluate words into the cell update core under a series of
// rule and grid-size settings and leaves the checking to the checker module.
// A short directed part exercises the wrapped corner, birth, survival and
// death, the one-cell grid and addresses outside the grid; random phases then
// follow, with the neighbourhood of every evaluated cell loaded beforehand.
// ----------------------------------------------------------------------------
module tb_life_like_automaton_cell_update_core;
  import lifeca_pkg::*;

  localparam int GRID_MAX       = 64;
  localparam int RESET_CYCLES   = 9;
  // A result arrives once its evaluate has left the busy states, and a load
  // may still be in flight when the last result arrives, so allow a margin.
  localparam int SETTLE_CYCLES  = 8;
  localparam int WORDS_PER_PHASE = 97;
  localparam int NUM_PHASES     = 8;
  localparam int LIMIT_CYCLES   = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [5:0]  in_cell_row;
  logic [5:0]  in_cell_col;
  logic [7:0]  in_red_value;
  logic        out_valid;
  logic [7:0]  out_next_color;
  logic        out_next_alive;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int compared;

  life_like_automaton_cell_update_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_red_value   (in_red_value),
    .out_valid      (out_valid),
    .out_next_color (out_next_color),
    .out_next_alive (out_next_alive),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // The checker sees exactly what the block sees and keeps its own score.
  lifeca_update_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .in_red_value   (in_red_value),
    .out_valid      (out_valid),
    .out_next_color (out_next_color),
    .out_next_alive (out_next_alive),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .pending        (pending),
    .compared       (compared)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Cells loaded so far, by physical position. The grid memory holds no
  // defined value until written, so an evaluate is only issued once all nine
  // cells of its wrapped neighbourhood have been loaded.
  bit cell_loaded [GRID_MAX][GRID_MAX];
  int grid_rows_eff = GRID_MAX;
  int grid_cols_eff = GRID_MAX;
  int focus_row;
  int focus_col;
  int counted_words = 0;
  int loads_sent = 0;
  int evals_sent = 0;
  int dropped_sent = 0;
  int settings_used = 0;
  bit quiet = 1'b0;

  function automatic int size_in_use(int v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  // At least half of the random red bytes are live; the rest carry any red byte at all.
  function automatic logic [7:0] random_red();
    if ($urandom_range(0, 1) == 0) return LIVE_RED;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one word and return at the falling edge after it has been taken.
  // Start is left high, so back-to-back words need no extra edge; when an
  // idle gap is chosen, start drops and the fields carry junk meanwhile.
  task automatic issue_word(logic req, int row, int col, logic [7:0] red);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 27) begin
      gap = $urandom_range(1, 3);
      start        <= 1'b0;
      in_req_type  <= 1'($urandom_range(0, 1));
      in_cell_row  <= 6'($urandom_range(0, 63));
      in_cell_col  <= 6'($urandom_range(0, 63));
      in_red_value <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= req;
    in_cell_row  <= row[5:0];
    in_cell_col  <= col[5:0];
    in_red_value <= red;
    // Busy only moves at a rising edge, so its value here is the one that
    // the next rising edge will see.
    while (busy) @(negedge clk);
    @(negedge clk);
    if (row < grid_rows_eff && col < grid_cols_eff) begin
      counted_words++;
      if (req == REQ_LOAD) begin
        cell_loaded[row][col] = 1'b1;
        loads_sent++;
      end else begin
        evals_sent++;
      end
    end else begin
      dropped_sent++;
    end
  endtask

  // Load whatever is still unwritten around the cell, then evaluate it.
  task automatic evaluate_with_neighbours(int row, int col);
    int dr, dc, rr, cc;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        rr = (row + dr + grid_rows_eff) % grid_rows_eff;
        cc = (col + dc + grid_cols_eff) % grid_cols_eff;
        if (!cell_loaded[rr][cc]) begin
          issue_word(REQ_LOAD, rr, cc, random_red());
        end
      end
    end
    issue_word(REQ_EVAL, row, col, 8'($urandom_range(0, 255)));
  endtask

  // Setup cycle, then access cycle; pready is always high.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Let every outstanding result come back, then give a late load time to
  // land before anything else happens.
  task automatic settle_block();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // All three registers are rewritten on every change of setting, with junk
  // in the bits above each register so that their dropping is exercised.
  task automatic apply_setting(logic [RULE_W-1:0] rule, int rows, int cols);
    settle_block();
    write_reg(REG_RULE, ($urandom & ~32'h3FFFF) | 32'(rule));
    write_reg(REG_ROWS, ($urandom & ~32'h7F) | 32'(rows[6:0]));
    write_reg(REG_COLS, ($urandom & ~32'h7F) | 32'(cols[6:0]));
    grid_rows_eff = size_in_use(rows[6:0]);
    grid_cols_eff = size_in_use(cols[6:0]);
    settings_used++;
  endtask

  // Most addresses fall in a small window (which may straddle the wrap) so
  // that neighbourhoods fill up and every neighbour count turns up.
  task automatic pick_in_grid(output int row, output int col);
    if ($urandom_range(0, 4) == 0) begin
      row = $urandom_range(0, grid_rows_eff - 1);
      col = $urandom_range(0, grid_cols_eff - 1);
    end else begin
      row = (focus_row + $urandom_range(0, 4)) % grid_rows_eff;
      col = (focus_col + $urandom_range(0, 4)) % grid_cols_eff;
    end
  endtask

  task automatic pick_outside_grid(output int row, output int col);
    if (grid_rows_eff < GRID_MAX && (grid_cols_eff == GRID_MAX || $urandom_range(0, 1))) begin
      row = $urandom_range(grid_rows_eff, GRID_MAX - 1);
      col = $urandom_range(0, GRID_MAX - 1);
    end else begin
      row = $urandom_range(0, GRID_MAX - 1);
      col = $urandom_range(grid_cols_eff, GRID_MAX - 1);
    end
  endtask

  task automatic run_random_phase(int words);
    int target, pick, row, col;
    bit room_outside;
    target = counted_words + words;
    room_outside = (grid_rows_eff < GRID_MAX) || (grid_cols_eff < GRID_MAX);
    focus_row = $urandom_range(0, grid_rows_eff - 1);
    focus_col = $urandom_range(0, grid_cols_eff - 1);
    while (counted_words < target) begin
      if ($urandom_range(0, 9) == 0) begin
        focus_row = $urandom_range(0, grid_rows_eff - 1);
        focus_col = $urandom_range(0, grid_cols_eff - 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pick_in_grid(row, col);
        evaluate_with_neighbours(row, col);
      end else if (pick < 88 || !room_outside) begin
        pick_in_grid(row, col);
        issue_word(REQ_LOAD, row, col, random_red());
      end else begin
        // Words outside the grid: loads must be ignored, evaluates silent.
        pick_outside_grid(row, col);
        issue_word(1'($urandom_range(0, 1)), row, col, random_red());
      end
    end
  endtask

  initial begin
    int p, rows, cols;
    logic [RULE_W-1:0] rule;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = REQ_LOAD;
    in_cell_row  = '0;
    in_cell_col  = '0;
    in_red_value = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: Conway's rule on the full 64 by 64 grid. Build the
    // neighbourhood of the top-left corner through the wrap: three live
    // cells in the bottom row, the rest dead (254 is the nearest non-live
    // red byte).
    issue_word(REQ_LOAD, 63, 63, LIVE_RED);
    issue_word(REQ_LOAD, 63, 0,  LIVE_RED);
    issue_word(REQ_LOAD, 63, 1,  LIVE_RED);
    issue_word(REQ_LOAD, 0,  63, 8'd254);
    issue_word(REQ_LOAD, 0,  0,  8'd0);
    issue_word(REQ_LOAD, 0,  1,  8'd128);
    issue_word(REQ_LOAD, 1,  63, 8'd127);
    issue_word(REQ_LOAD, 1,  0,  8'd1);
    issue_word(REQ_LOAD, 1,  1,  8'd0);
    // Dead cell with three neighbours is born.
    issue_word(REQ_EVAL, 0, 0, 8'd255);
    // The same count keeps a live cell alive.
    issue_word(REQ_LOAD, 0, 0, LIVE_RED);
    issue_word(REQ_EVAL, 0, 0, 8'd0);
    // A fourth neighbour kills it by overcrowding.
    issue_word(REQ_LOAD, 1, 1, LIVE_RED);
    issue_word(REQ_EVAL, 0, 0, 8'd0);
    // The other three corners wrap the other way on one axis or on both.
    evaluate_with_neighbours(63, 63);
    evaluate_with_neighbours(0, 63);
    evaluate_with_neighbours(63, 0);

    // One-cell grid: all eight neighbours are the cell itself. The rule
    // keeps a live cell with eight neighbours and births one with none.
    apply_setting(18'h20001, 1, 1);
    issue_word(REQ_LOAD, 0, 0, LIVE_RED);
    issue_word(REQ_EVAL, 0, 0, 8'd0);
    issue_word(REQ_LOAD, 0, 0, 8'd0);
    issue_word(REQ_EVAL, 0, 0, 8'd0);
    // Outside the grid: the load must not land and the evaluate gives no
    // result; the dead cell at the origin is then evaluated again and born.
    issue_word(REQ_LOAD, 0, 1, LIVE_RED);
    issue_word(REQ_EVAL, 2, 0, 8'd0);
    issue_word(REQ_EVAL, 0, 0, 8'd0);

    // Random phases under a range of settings: full grid, a zero size and an
    // over-range size (which act as one and as the maximum), the all-zero
    // and all-one rules, thin strips, and random settings. One phase runs
    // without any idle cycles at all.
    for (p = 0; p < NUM_PHASES; p++) begin
      rule = RULE_W'($urandom);
      case (p)
        0: begin rows = 64; cols = 64; end
        1: begin rule = '0; rows = 0; cols = 127; end
        2: begin rule = '1; rows = 2; cols = 2; end
        3: begin rows = 3; cols = 64; end
        4: begin rows = 64; cols = 1; end
        default: begin
          rows = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
          cols = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        end
      endcase
      apply_setting(rule, rows, cols);
      quiet = (p == 3);
      run_random_phase(WORDS_PER_PHASE);
    end
    quiet = 1'b0;

    settle_block();
    $display("Covered %0d loads, %0d evaluates and %0d out-of-grid words under %0d settings;",
             loads_sent, evals_sent, dropped_sent, settings_used + 1);
    $display("%0d result words compared, %0d mismatches.", compared, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/lifeca_pkg.sv
src/lifeca_row_mem.sv
src/lifeca_nbr_count.sv
src/life_like_automaton_cell_update_core.sv
src/lifeca_checker.sv
dv/lifeca_update_checker.sv
dv/tb_life_like_automaton_cell_update_core.sv
